// ----- rtl/sal_pkg.sv -----
// shared types and constants for the sorted array list
package sal_pkg;

    // list geometry
    localparam int CAPACITY = 8;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 3;
    localparam int OP_W     = 2;
    localparam int VAL_W    = 32;

    // operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic execute;
    } t_dp_cmd;

endpackage

// ----- rtl/sal_if.sv -----
// request and response channel interfaces
interface sal_req_if import sal_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         opcode;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;

    modport source (output valid, opcode, value, position, input ready);
    modport sink   (input valid, opcode, value, position, output ready);
endinterface

interface sal_rsp_if import sal_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    ok;
    logic [CNT_W-1:0]        count;
    logic signed [VAL_W-1:0] read_value;

    modport source (output valid, ok, count, read_value, input ready);
    modport sink   (input valid, ok, count, read_value, output ready);
endinterface

// ----- rtl/sal_ctrl.sv -----
// controller state machine: accept, execute, respond
module sal_ctrl import sal_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_RESP;
            end
            ST_RESP: begin
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready    = 1'b0;
        o_out_valid   = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.execute = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ST_EXEC: begin
                o_cmd.execute = 1'b1;
            end
            ST_RESP: begin
                o_out_valid = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- rtl/sal_dp.sv -----
// datapath: sorted slot row, count and response register
module sal_dp import sal_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    input  logic [OP_W-1:0]         i_opcode,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic [POS_W-1:0]        i_position,
    output logic                    o_ok,
    output logic [CNT_W-1:0]        o_count,
    output logic signed [VAL_W-1:0] o_read_value
);

    logic [OP_W-1:0]         r_op;
    logic signed [VAL_W-1:0] r_val;
    logic [POS_W-1:0]        r_pos;
    logic signed [VAL_W-1:0] r_slot [CAPACITY];
    logic [CNT_W-1:0]        r_count;
    logic                    r_ok;
    logic signed [VAL_W-1:0] r_rd;

    logic signed [VAL_W-1:0] ins_next [CAPACITY];
    logic signed [VAL_W-1:0] del_next [CAPACITY];
    logic [CAPACITY-1:0]     gt;
    logic                    full;
    logic                    pos_valid;

    assign full      = (r_count == CNT_W'(CAPACITY));
    assign pos_valid = ({{(CNT_W > POS_W ? CNT_W - POS_W : 1){1'b0}}, r_pos} < r_count)
                       && ({1'b0, r_pos} < (POS_W + 1)'(CAPACITY));

    // per-slot compare and shift
    for (genvar i = 0; i < CAPACITY; i++) begin : g_slot
        localparam logic [CNT_W-1:0] K  = CNT_W'(i);
        localparam logic [POS_W:0]   KP = (POS_W + 1)'(i);
        logic occupied;

        assign occupied = (K < r_count);
        assign gt[i]    = occupied && (r_slot[i] > r_val);

        // insert: larger entries move up, value lands after equal ones
        if (i == 0) begin : g_first
            assign ins_next[i] = (gt[i] || K == r_count) ? r_val : r_slot[i];
        end else begin : g_rest
            assign ins_next[i] = gt[i-1] ? r_slot[i-1] :
                                 ((gt[i] || K == r_count) ? r_val : r_slot[i]);
        end

        // delete: later occupied entries move down
        if (i == CAPACITY - 1) begin : g_last
            assign del_next[i] = r_slot[i];
        end else begin : g_body
            assign del_next[i] = (KP >= {1'b0, r_pos} && (K + 1'b1) < r_count)
                                 ? r_slot[i+1] : r_slot[i];
        end
    end

    // input beat capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_opcode;
            r_val <= i_value;
            r_pos <= i_position;
        end
    end

    // slot row update
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            if (r_op == OP_INSERT && !full) begin
                r_slot <= ins_next;
            end else if (r_op == OP_DELETE && pos_valid) begin
                r_slot <= del_next;
            end
        end
    end

    // fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.execute) begin
            if (r_op == OP_INSERT && !full) begin
                r_count <= r_count + 1'b1;
            end else if (r_op == OP_DELETE && pos_valid) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // response register
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            case (r_op)
                OP_INSERT: begin
                    r_ok <= !full;
                    r_rd <= '0;
                end
                OP_DELETE: begin
                    r_ok <= pos_valid;
                    r_rd <= '0;
                end
                OP_READ: begin
                    r_ok <= pos_valid;
                    r_rd <= pos_valid ? r_slot[IDX_W'(r_pos)] : '0;
                end
                default: begin
                    r_ok <= 1'b0;
                    r_rd <= '0;
                end
            endcase
        end
    end

    assign o_ok         = r_ok;
    assign o_count      = r_count;
    assign o_read_value = r_rd;

    // count stays within capacity
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    // a successful insert adds exactly one entry
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.execute && r_op == OP_INSERT && !full |=> r_count == $past(r_count) + 1'b1)
        else $error("insert did not grow the list");

    // a read never changes the count
    a_read_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.execute && r_op == OP_READ |=> r_count == $past(r_count))
        else $error("read changed the count");

    // failed operations report no data
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.execute |=> r_ok || r_rd == '0)
        else $error("nonzero read value on failure");

endmodule

// ----- rtl/sorted_array_list.sv -----
// sorted array list: ascending list with insert, delete at position and read
// flow: the request beat is captured in idle, executed in the exec state, then held as a valid response
// a new request is accepted only once the previous response has been taken (accept, execute, respond)
// every slot compares and shifts in parallel, so any operation completes within the exec state
// reset: synchronous active-low, empties the list and returns to idle
module sorted_array_list import sal_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sal_req_if.sink   i_req,
    sal_rsp_if.source o_rsp
);

    t_dp_cmd cmd;

    // controller
    sal_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd)
    );

    // datapath
    sal_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_opcode     (i_req.opcode),
        .i_value      (i_req.value),
        .i_position   (i_req.position),
        .o_ok         (o_rsp.ok),
        .o_count      (o_rsp.count),
        .o_read_value (o_rsp.read_value)
    );

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the sorted array list: directed table then random beats
module testbench;
    import sal_pkg::*;

    // opcode left unused by the block
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

    localparam int RESET_CYCLES   = 11;
    localparam int RAND_PER_PHASE = 180;
    localparam int MODE_SPAN      = 30;
    localparam int STALL_CYCLES   = 200;
    localparam int DRAIN_CYCLES   = 8;
    localparam int QUIET_LIMIT    = 2000;
    localparam int MAX_REPORTS    = 10;
    localparam int NUM_DIR        = 25;

    typedef struct packed {
        logic                    ok;
        logic [CNT_W-1:0]        count;
        logic signed [VAL_W-1:0] read_value;
    } t_list_result;

    typedef struct packed {
        logic [OP_W-1:0]         opcode;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        position;
        logic                    typed;
        t_list_result            result;
    } t_dir_row;

    // directed rows; typed results only where they are obvious
    localparam t_dir_row DIR_ROWS [NUM_DIR] = '{
        '{OP_READ,   32'sd0,  3'd0, 1'b1, '{1'b0, 4'd0, 32'sd0}},
        '{OP_DELETE, 32'sd0,  3'd0, 1'b1, '{1'b0, 4'd0, 32'sd0}},
        '{OP_READ,   32'sd0,  3'd7, 1'b1, '{1'b0, 4'd0, 32'sd0}},
        '{OP_UNUSED, VAL_MAX, 3'd7, 1'b1, '{1'b0, 4'd0, 32'sd0}},
        '{OP_INSERT, VAL_MAX, 3'd0, 1'b1, '{1'b1, 4'd1, 32'sd0}},
        '{OP_INSERT, VAL_MIN, 3'd0, 1'b1, '{1'b1, 4'd2, 32'sd0}},
        '{OP_READ,   32'sd0,  3'd0, 1'b1, '{1'b1, 4'd2, VAL_MIN}},
        '{OP_READ,   32'sd0,  3'd1, 1'b1, '{1'b1, 4'd2, VAL_MAX}},
        '{OP_READ,   32'sd0,  3'd2, 1'b1, '{1'b0, 4'd2, 32'sd0}},
        '{OP_INSERT, 32'sd0,  3'd7, 1'b1, '{1'b1, 4'd3, 32'sd0}},
        '{OP_INSERT, 32'sd0,  3'd0, 1'b0, '0},
        '{OP_INSERT, -32'sd1, 3'd0, 1'b0, '0},
        '{OP_INSERT, 32'sd1,  3'd0, 1'b0, '0},
        '{OP_INSERT, VAL_MAX, 3'd0, 1'b0, '0},
        '{OP_INSERT, VAL_MIN, 3'd0, 1'b1, '{1'b1, 4'd8, 32'sd0}},
        '{OP_INSERT, 32'sd5,  3'd0, 1'b1, '{1'b0, 4'd8, 32'sd0}},
        '{OP_READ,   32'sd0,  3'd7, 1'b1, '{1'b1, 4'd8, VAL_MAX}},
        '{OP_READ,   32'sd0,  3'd0, 1'b1, '{1'b1, 4'd8, VAL_MIN}},
        '{OP_UNUSED, 32'sd0,  3'd0, 1'b1, '{1'b0, 4'd8, 32'sd0}},
        '{OP_DELETE, 32'sd0,  3'd7, 1'b1, '{1'b1, 4'd7, 32'sd0}},
        '{OP_DELETE, 32'sd0,  3'd0, 1'b1, '{1'b1, 4'd6, 32'sd0}},
        '{OP_DELETE, 32'sd0,  3'd3, 1'b0, '0},
        '{OP_READ,   32'sd0,  3'd5, 1'b1, '{1'b0, 4'd5, 32'sd0}},
        '{OP_DELETE, 32'sd0,  3'd6, 1'b1, '{1'b0, 4'd5, 32'sd0}},
        '{OP_READ,   32'sd0,  3'd2, 1'b0, '0}
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    sal_req_if req_if ();
    sal_rsp_if rsp_if ();

    sorted_array_list dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // shadow copy of the list contents
    logic signed [VAL_W-1:0] shadow_entries [CAPACITY];
    int                      shadow_count = 0;

    t_list_result pending_results [$];
    t_list_result got_result;
    t_list_result want_result;

    int unsigned tx_idle_pct = 31;
    int unsigned rx_idle_pct = 55;
    logic        stall_go    = 1'b0;
    int          mismatches  = 0;
    int          quiet_cycles = 0;

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // apply one operation to the shadow list and return the result it gives
    function automatic t_list_result list_apply(input logic [OP_W-1:0] op,
            input logic signed [VAL_W-1:0] v, input logic [POS_W-1:0] p);
        t_list_result r;
        int           i;
        r = '0;
        case (op)
            OP_INSERT: begin
                if (shadow_count < CAPACITY) begin
                    // equal values stay ahead of the new one
                    i = shadow_count;
                    while (i > 0 && shadow_entries[i-1] > v) begin
                        shadow_entries[i] = shadow_entries[i-1];
                        i--;
                    end
                    shadow_entries[i] = v;
                    shadow_count++;
                    r.ok = 1'b1;
                end
            end
            OP_DELETE: begin
                if (int'(p) < shadow_count) begin
                    for (i = int'(p); i + 1 < shadow_count; i++)
                        shadow_entries[i] = shadow_entries[i+1];
                    shadow_count--;
                    r.ok = 1'b1;
                end
            end
            OP_READ: begin
                if (int'(p) < shadow_count) begin
                    r.ok         = 1'b1;
                    r.read_value = shadow_entries[p];
                end
            end
            default: begin
            end
        endcase
        r.count = shadow_count[CNT_W-1:0];
        return r;
    endfunction

    // offer one request beat, wait for acceptance, queue what it should return
    task automatic send_request(input logic [OP_W-1:0] op, input logic signed [VAL_W-1:0] v,
            input logic [POS_W-1:0] p, input logic typed, input t_list_result typed_res);
        t_list_result predicted;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.opcode   <= op;
        req_if.value    <= v;
        req_if.position <= p;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        predicted = list_apply(op, v, p);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    // request side: reset, directed table, random phases, drain
    initial begin
        int unsigned             pick;
        int                      offset;
        logic [OP_W-1:0]         op;
        logic signed [VAL_W-1:0] v;
        logic [POS_W-1:0]        p;
        req_if.valid    <= 1'b0;
        req_if.opcode   <= OP_INSERT;
        req_if.value    <= '0;
        req_if.position <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int n = 0; n < NUM_DIR; n++)
            send_request(DIR_ROWS[n].opcode, DIR_ROWS[n].value, DIR_ROWS[n].position,
                         DIR_ROWS[n].typed, DIR_ROWS[n].result);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 31;
                    rx_idle_pct = 55;
                end
                1: begin
                    tx_idle_pct = 55;
                    rx_idle_pct = 31;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                    stall_go   <= 1'b1;
                end
            endcase
            for (int k = 0; k < RAND_PER_PHASE; k++) begin
                // alternate fill-heavy and drain-heavy stretches
                pick = $urandom_range(0, 99);
                if ((k / MODE_SPAN) % 2 == 0)
                    op = (pick < 55) ? OP_INSERT : (pick < 70) ? OP_DELETE :
                         (pick < 95) ? OP_READ : OP_UNUSED;
                else
                    op = (pick < 15) ? OP_INSERT : (pick < 60) ? OP_DELETE :
                         (pick < 95) ? OP_READ : OP_UNUSED;

                // small values give duplicates, extremes hit the ends
                pick = $urandom_range(0, 9);
                if (pick < 4) begin
                    offset = $urandom_range(0, 15);
                    v      = offset - 8;
                end else if (pick == 4) begin
                    case ($urandom_range(0, 3))
                        0:       v = VAL_MIN;
                        1:       v = VAL_MAX;
                        2:       v = '0;
                        default: v = -1;
                    endcase
                end else begin
                    v = $urandom;
                end

                // mostly occupied positions, sometimes anything
                if (shadow_count > 0 && $urandom_range(0, 99) < 80)
                    p = POS_W'($urandom_range(0, shadow_count - 1));
                else
                    p = POS_W'($urandom_range(0, 7));

                send_request(op, v, p, 1'b0, '0);
            end
        end
        req_if.valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // response side: random backpressure plus one long hold-off
    initial begin
        logic stall_done;
        stall_done = 1'b0;
        rsp_if.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (stall_go && !stall_done) begin
                stall_done = 1'b1;
                repeat (STALL_CYCLES) begin
                    rsp_if.ready <= 1'b0;
                    @(posedge i_clk);
                end
            end
            rsp_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            @(posedge i_clk);
        end
    end

    // compare each response beat with the oldest queued result
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;

        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got_result.ok         = rsp_if.ok;
            got_result.count      = rsp_if.count;
            got_result.read_value = rsp_if.read_value;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected response beat: ok=%0b count=%0d read_value=%0d",
                             got_result.ok, got_result.count, got_result.read_value);
            end else begin
                want_result = pending_results.pop_front();
                if (got_result !== want_result) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("mismatch: want ok=%0b count=%0d read_value=%0d",
                                 want_result.ok, want_result.count, want_result.read_value);
                        $display("           got ok=%0b count=%0d read_value=%0d",
                                 got_result.ok, got_result.count, got_result.read_value);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no beat on either channel
    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
